@@ src/dtok_pkg.sv @@
package dtok_pkg;

  localparam int unsigned COUNT_BITS_DEFAULT = 32;
  localparam int unsigned FIFO_DEPTH_DEFAULT = 2;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic       CMD_BYTE = 1'b0;
  localparam logic       CMD_END  = 1'b1;

  localparam logic [31:0] MAG_CAP = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

  typedef enum logic [2:0] {
    CLS_DIGIT = 3'd0,
    CLS_MINUS = 3'd1,
    CLS_DELIM = 3'd2,
    CLS_OTHER = 3'd3,
    CLS_END   = 3'd4
  } cls_e;

  typedef enum logic [1:0] {
    KIND_NUMBER    = 2'd0,
    KIND_DONE      = 2'd1,
    KIND_ERR_CHAR  = 2'd2,
    KIND_ERR_EMPTY = 2'd3
  } kind_e;

  typedef struct packed {
    cls_e       cls;
    logic [3:0] digit;
  } op_t;

endpackage

@@ src/dtok_front.sv @@
module dtok_front (
  input  logic            in_valid_i,
  input  logic            command_i,
  input  logic [7:0]      text_byte_i,
  input  logic            q_full_i,
  output logic            in_ready_o,
  output logic            push_o,
  output dtok_pkg::op_t   op_o
);

  logic [3:0] digit_ofs;

  assign digit_ofs  = 4'(text_byte_i - dtok_pkg::CHAR_ZERO);
  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    op_o.digit = digit_ofs;
    if (command_i == dtok_pkg::CMD_END) begin
      op_o.cls = dtok_pkg::CLS_END;
    end else if (text_byte_i >= dtok_pkg::CHAR_ZERO && text_byte_i <= dtok_pkg::CHAR_NINE) begin
      op_o.cls = dtok_pkg::CLS_DIGIT;
    end else if (text_byte_i == dtok_pkg::CHAR_MINUS) begin
      op_o.cls = dtok_pkg::CLS_MINUS;
    end else if (text_byte_i == dtok_pkg::CHAR_SPACE || text_byte_i == dtok_pkg::CHAR_TAB ||
                 text_byte_i == dtok_pkg::CHAR_NL) begin
      op_o.cls = dtok_pkg::CLS_DELIM;
    end else begin
      op_o.cls = dtok_pkg::CLS_OTHER;
    end
  end

endmodule

@@ src/dtok_fifo.sv @@
module dtok_fifo #(
  parameter int unsigned DEPTH = dtok_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  dtok_pkg::op_t  push_op_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output dtok_pkg::op_t  op_o
);

  localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);
  localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);
  localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(DEPTH);

  dtok_pkg::op_t        entry_q [DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_BITS-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CNT_BITS-1:0]  cnt_q, cnt_d;
  logic                 do_push, do_pop;

  assign full_o  = (cnt_q == CNT_FULL);
  assign valid_o = (cnt_q != '0);
  assign op_o    = entry_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_op_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_FULL)
    else $error("queue fill count beyond depth");

  a_ptr_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with diverged pointers");

endmodule

@@ src/dtok_back.sv @@
module dtok_back #(
  parameter int unsigned COUNT_BITS = dtok_pkg::COUNT_BITS_DEFAULT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                op_valid_i,
  input  dtok_pkg::op_t       op_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [1:0]          kind_o,
  output logic signed [31:0]  number_o,
  output logic [31:0]         total_o,
  output logic                last_of_run_o
);

  // token and stream state
  logic [31:0]           mag_q, mag_d;
  logic                  neg_q, neg_d;
  logic                  in_tok_q, in_tok_d;
  logic [1:0]            len_q, len_d;
  logic                  bad_q, bad_d;
  logic                  halted_q, halted_d;
  logic [COUNT_BITS-1:0] count_q, count_d;

  // output register
  logic                  out_valid_q;
  dtok_pkg::kind_e       kind_q;
  logic [31:0]           number_q;
  logic [31:0]           total_q;
  logic                  last_q;

  logic [COUNT_BITS-1:0] count_inc;
  logic [31:0]           tot_cur, tot_inc;
  logic [35:0]           mag_next;
  logic [31:0]           fin_val;
  logic                  res_valid, res_last, keep_op, fire, out_free;
  dtok_pkg::kind_e       res_kind;
  logic [31:0]           res_num, res_total;

  assign count_inc = (count_q == '1) ? count_q : count_q + 1'b1;

  if (COUNT_BITS > 32) begin : g_wide
    assign tot_cur = (|count_q[COUNT_BITS-1:32])   ? '1 : count_q[31:0];
    assign tot_inc = (|count_inc[COUNT_BITS-1:32]) ? '1 : count_inc[31:0];
  end else begin : g_narrow
    assign tot_cur = 32'(count_q);
    assign tot_inc = 32'(count_inc);
  end

  // times ten as two shifts, then the new digit
  assign mag_next = {1'b0, mag_q, 3'b000} + {3'b000, mag_q, 1'b0} + {32'd0, op_i.digit};
  assign fin_val  = neg_q ? (32'd0 - mag_q) : (mag_q[31] ? dtok_pkg::POS_MAX : mag_q);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    mag_d     = mag_q;
    neg_d     = neg_q;
    in_tok_d  = in_tok_q;
    len_d     = len_q;
    bad_d     = bad_q;
    halted_d  = halted_q;
    count_d   = count_q;
    res_valid = 1'b0;
    res_last  = 1'b1;
    res_kind  = dtok_pkg::KIND_DONE;
    res_num   = '0;
    res_total = tot_cur;
    keep_op   = 1'b0;

    if (op_valid_i) begin
      unique case (op_i.cls) inside
        dtok_pkg::CLS_DIGIT, dtok_pkg::CLS_MINUS, dtok_pkg::CLS_OTHER: begin
          if (!halted_q) begin
            in_tok_d = 1'b1;
            if (op_i.cls == dtok_pkg::CLS_MINUS && len_q == 2'd0) begin
              neg_d = 1'b1;
            end else if (op_i.cls == dtok_pkg::CLS_DIGIT) begin
              mag_d = (mag_next >= {4'd0, dtok_pkg::MAG_CAP}) ? dtok_pkg::MAG_CAP
                                                              : mag_next[31:0];
            end else begin
              bad_d = 1'b1;
            end
            len_d = (len_q == 2'd2) ? len_q : len_q + 2'd1;
          end
        end
        dtok_pkg::CLS_DELIM, dtok_pkg::CLS_END: begin
          if (op_i.cls == dtok_pkg::CLS_END && halted_q) begin
            halted_d = 1'b0;
            count_d  = '0;
          end else if (in_tok_q) begin
            res_valid = 1'b1;
            if (bad_q) begin
              res_kind = dtok_pkg::KIND_ERR_CHAR;
              halted_d = 1'b1;
            end else begin
              res_kind  = dtok_pkg::KIND_NUMBER;
              res_num   = fin_val;
              count_d   = count_inc;
              res_total = tot_inc;
            end
            // end with a good token: number now, completion from the same item next
            if (op_i.cls == dtok_pkg::CLS_END) begin
              if (bad_q) begin
                halted_d = 1'b0;
                count_d  = '0;
              end else begin
                res_last = 1'b0;
                keep_op  = 1'b1;
              end
            end
          end else if (op_i.cls == dtok_pkg::CLS_END) begin
            res_valid = 1'b1;
            res_kind  = (count_q == '0) ? dtok_pkg::KIND_ERR_EMPTY : dtok_pkg::KIND_DONE;
            count_d   = '0;
          end
          if (op_i.cls == dtok_pkg::CLS_END || in_tok_q) begin
            mag_d    = '0;
            neg_d    = 1'b0;
            in_tok_d = 1'b0;
            len_d    = '0;
            bad_d    = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign fire  = op_valid_i && (!res_valid || out_free);
  assign pop_o = fire && !keep_op;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_q       <= '0;
      neg_q       <= 1'b0;
      in_tok_q    <= 1'b0;
      len_q       <= '0;
      bad_q       <= 1'b0;
      halted_q    <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        mag_q    <= mag_d;
        neg_q    <= neg_d;
        in_tok_q <= in_tok_d;
        len_q    <= len_d;
        bad_q    <= bad_d;
        halted_q <= halted_d;
        count_q  <= count_d;
      end
      if (fire && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res_valid) begin
      kind_q   <= res_kind;
      number_q <= res_num;
      total_q  <= res_total;
      last_q   <= res_last;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign number_o      = number_q;
  assign total_o       = total_q;
  assign last_of_run_o = last_q;

  a_mag_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag_q <= dtok_pkg::MAG_CAP)
    else $error("magnitude beyond saturation cap");

  a_halt_no_tok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |-> (!in_tok_q && !bad_q))
    else $error("token state left while halted");

  a_non_num_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q != dtok_pkg::KIND_NUMBER) |-> last_q)
    else $error("non-number item not marked last");

  a_keep_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && keep_op) |=> (out_valid_q && kind_q == dtok_pkg::KIND_NUMBER && !last_q))
    else $error("held end item without a number item");

endmodule

@@ src/decimal_integer_tokenizer_unit.sv @@
// Decimal integer tokenizer: takes one text byte (command 0) or an end of stream
// (command 1) per item and returns signed 32-bit values for whitespace-separated
// tokens, an invalid character error, and done or empty input at the end of a
// stream. Items are classified at the input, pass through a short queue and are
// executed one per cycle by the back end, so the block sustains one item per clock
// unless the output register holds a result that is not taken. An end item that
// closes a good token is executed twice, for the number and then for the completion
// item; every other item is executed once. Results leave through a single output
// register; an accepted input item passes through the queue first, and its result
// is then registered in the output register. The value counter is COUNT_BITS wide
// and saturates; total reports it clamped to 32 bits.
module decimal_integer_tokenizer_unit #(
  parameter int unsigned COUNT_BITS = dtok_pkg::COUNT_BITS_DEFAULT,
  parameter int unsigned FIFO_DEPTH = dtok_pkg::FIFO_DEPTH_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               command_i,
  input  logic [7:0]         text_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         kind_o,
  output logic signed [31:0] number_o,
  output logic [31:0]        total_o,
  output logic               last_of_run_o
);

  dtok_pkg::op_t push_op, head_op;
  logic          push, q_full, head_valid, pop;

  dtok_front u_front (
    .in_valid_i  (in_valid_i),
    .command_i   (command_i),
    .text_byte_i (text_byte_i),
    .q_full_i    (q_full),
    .in_ready_o  (in_ready_o),
    .push_o      (push),
    .op_o        (push_op)
  );

  dtok_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .push_op_i (push_op),
    .pop_i     (pop),
    .full_o    (q_full),
    .valid_o   (head_valid),
    .op_o      (head_op)
  );

  dtok_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_valid_i    (head_valid),
    .op_i          (head_op),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .kind_o        (kind_o),
    .number_o      (number_o),
    .total_o       (total_o),
    .last_of_run_o (last_of_run_o)
  );

endmodule
